/* rtl/r2q_pkg.sv */
// Shared types, widths and helper functions for the rotation matrix to quaternion core.
// No dependencies; the prep, sqrt, div and top-level rtl files import this package.
`default_nettype none
package r2q_pkg;

   localparam int FRAC_BITS = 14;
   localparam int DATA_W    = 16;
   localparam int MAT_N     = 9;
   localparam int LANES     = 3;
   localparam int DIFF_W    = DATA_W + 2;
   localparam int RADS_W    = DATA_W + 3;
   localparam int RAD_W     = 32;
   localparam int ROOT_W    = RAD_W / 2;
   localparam int REM_W     = ROOT_W + 2;
   localparam int QUO_W     = 16;
   localparam int DEN_W     = ROOT_W + 1;
   localparam int NUM_W     = RAD_W;
   localparam int PREM_W    = DEN_W + 1;

   localparam logic signed [RADS_W-1:0] ONE_FX = RADS_W'(2 ** FRAC_BITS);
   localparam logic [QUO_W-1:0] SAT_POS = 16'h7FFF;
   localparam logic [QUO_W-1:0] SAT_NEG = 16'h8000;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef enum logic [1:0] {
      SLOT_W = 2'd0,
      SLOT_X = 2'd1,
      SLOT_Y = 2'd2,
      SLOT_Z = 2'd3
   } slot_type;

   // element r*3+c in bits [16*(r*3+c) +: 16]
   typedef logic [MAT_N-1:0][DATA_W-1:0] mat_type;

   typedef struct packed {
      logic                          bad;
      slot_type                      slot;
      logic [LANES-1:0][DIFF_W-1:0]  diff;
   } side_type;

   typedef struct packed {
      side_type          side;
      logic [RAD_W-1:0]  rad;
   } prep_type;

   typedef struct packed {
      side_type           side;
      logic [ROOT_W-1:0]  root;
   } root_type;

   typedef struct packed {
      logic                          bad;
      slot_type                      slot;
      logic [ROOT_W-1:0]             half;
      logic [LANES-1:0][QUO_W-1:0]   quot;
      logic [LANES-1:0]              ovf;
      logic [LANES-1:0]              neg;
   } quot_type;

   function automatic axis_type next_axis(axis_type a);
      axis_type n;
      case (a)
         AXIS_X:  n = AXIS_Y;
         AXIS_Y:  n = AXIS_Z;
         AXIS_Z:  n = AXIS_X;
         default: n = AXIS_X;
      endcase
      return n;
   endfunction

   function automatic logic signed [DATA_W-1:0] elem(mat_type m, axis_type r, axis_type c);
      logic [3:0] idx;
      idx = 4'(r) * 4'd3 + 4'(c);
      return $signed(m[idx]);
   endfunction

endpackage
`default_nettype wire

/* rtl/r2q_prep.sv */
// Front end: trace, largest-diagonal pick, radicand and numerator terms (two stages).
// Depends on r2q_pkg.
`default_nettype none
module r2q_prep (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  r2q_pkg::mat_type   in_mat,
   output logic               out_valid,
   output r2q_pkg::prep_type  out_prep
);
   import r2q_pkg::*;

   logic signed [DATA_W-1:0] m00, m11, m22;
   logic signed [DIFF_W-1:0] trace;
   axis_type                 axis_in;

   logic     va_ff;
   mat_type  mat_a_ff;
   logic     tpos_a_ff;
   axis_type axis_a_ff;

   always_comb begin
      m00 = $signed(in_mat[0]);
      m11 = $signed(in_mat[4]);
      m22 = $signed(in_mat[8]);
      trace = DIFF_W'(m00) + DIFF_W'(m11) + DIFF_W'(m22);
      axis_in = AXIS_X;
      if (m11 > m00) axis_in = AXIS_Y;
      if (m22 > ((axis_in == AXIS_Y) ? m11 : m00)) axis_in = AXIS_Z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= in_valid;
      end
      if (adv) begin
         mat_a_ff  <= in_mat;
         tpos_a_ff <= (trace > 0);
         axis_a_ff <= axis_in;
      end
   end

   axis_type                 ai, aj, ak;
   logic signed [RADS_W-1:0] rad;
   side_type                 side_in;
   logic                     vb_ff;
   prep_type                 prep_ff;

   always_comb begin
      ai = axis_a_ff;
      aj = next_axis(ai);
      ak = next_axis(aj);
      side_in = '0;
      if (tpos_a_ff) begin
         rad = ONE_FX + RADS_W'(elem(mat_a_ff, AXIS_X, AXIS_X))
             + RADS_W'(elem(mat_a_ff, AXIS_Y, AXIS_Y))
             + RADS_W'(elem(mat_a_ff, AXIS_Z, AXIS_Z));
         side_in.slot    = SLOT_W;
         side_in.diff[0] = DIFF_W'(elem(mat_a_ff, AXIS_Y, AXIS_Z))
                         - DIFF_W'(elem(mat_a_ff, AXIS_Z, AXIS_Y));
         side_in.diff[1] = DIFF_W'(elem(mat_a_ff, AXIS_Z, AXIS_X))
                         - DIFF_W'(elem(mat_a_ff, AXIS_X, AXIS_Z));
         side_in.diff[2] = DIFF_W'(elem(mat_a_ff, AXIS_X, AXIS_Y))
                         - DIFF_W'(elem(mat_a_ff, AXIS_Y, AXIS_X));
      end else begin
         rad = ONE_FX + RADS_W'(elem(mat_a_ff, ai, ai))
             - RADS_W'(elem(mat_a_ff, aj, aj))
             - RADS_W'(elem(mat_a_ff, ak, ak));
         side_in.slot    = slot_type'(2'(ai) + 2'd1);
         side_in.diff[0] = DIFF_W'(elem(mat_a_ff, aj, ak)) - DIFF_W'(elem(mat_a_ff, ak, aj));
         side_in.diff[1] = DIFF_W'(elem(mat_a_ff, ai, aj)) + DIFF_W'(elem(mat_a_ff, aj, ai));
         side_in.diff[2] = DIFF_W'(elem(mat_a_ff, ai, ak)) + DIFF_W'(elem(mat_a_ff, ak, ai));
      end
      side_in.bad = !tpos_a_ff && (rad <= 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (adv) begin
         vb_ff <= va_ff;
      end
      if (adv) begin
         prep_ff.side <= side_in;
         prep_ff.rad  <= side_in.bad ? '0 : (RAD_W'(rad) << FRAC_BITS);
      end
   end

   assign out_valid = vb_ff;
   assign out_prep  = prep_ff;

endmodule
`default_nettype wire

/* rtl/r2q_sqrt.sv */
// Floor square root, one result bit per pipeline stage, side data carried alongside.
// Depends on r2q_pkg.
`default_nettype none
module r2q_sqrt (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  r2q_pkg::prep_type  in_prep,
   output logic               out_valid,
   output r2q_pkg::root_type  out_root
);
   import r2q_pkg::*;

   logic              v_ff    [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   side_type          side_ff [ROOT_W];

   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      logic              pv;
      logic [REM_W-1:0]  prem;
      logic [ROOT_W-1:0] proot;
      logic [RAD_W-1:0]  prad;
      side_type          pside;
      logic [REM_W-1:0]  rem_sh, test;
      logic              ge;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (s == 0) begin : g_first
         assign pv    = in_valid;
         assign prem  = '0;
         assign proot = '0;
         assign prad  = in_prep.rad;
         assign pside = in_prep.side;
      end else begin : g_next
         assign pv    = v_ff[s-1];
         assign prem  = rem_ff[s-1];
         assign proot = root_ff[s-1];
         assign prad  = rad_ff[s-1];
         assign pside = side_ff[s-1];
      end

      always_comb begin
         rem_sh  = {prem[REM_W-3:0], prad[RAD_W-1 -: 2]};
         test    = {proot, 2'b01};
         ge      = (rem_sh >= test);
         rem_in  = ge ? (rem_sh - test) : rem_sh;
         root_in = {proot[ROOT_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv) begin
            v_ff[s] <= pv;
         end
         if (adv) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            rad_ff[s]  <= prad << 2;
            side_ff[s] <= pside;
         end
      end
   end

   assign out_valid     = v_ff[ROOT_W-1];
   assign out_root.root = root_ff[ROOT_W-1];
   assign out_root.side = side_ff[ROOT_W-1];

endmodule
`default_nettype wire

/* rtl/r2q_div.sv */
// Three-lane restoring divider: |d| * 2^FRAC_BITS / (2S), rounded, one quotient bit a stage.
// Depends on r2q_pkg.
`default_nettype none
module r2q_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  r2q_pkg::root_type  in_root,
   output logic               out_valid,
   output r2q_pkg::quot_type  out_quot
);
   import r2q_pkg::*;

   localparam int NST = QUO_W + 1;

   typedef struct packed {
      logic              bad;
      slot_type          slot;
      logic [ROOT_W-1:0] half;
      logic [DEN_W-1:0]  den;
      logic [LANES-1:0]  ovf;
      logic [LANES-1:0]  neg;
   } meta_type;

   logic                         v_ff    [NST];
   meta_type                     meta_ff [NST];
   logic [LANES-1:0][PREM_W-1:0] prem_ff [NST];
   logic [LANES-1:0][QUO_W-1:0]  nlow_ff [NST];
   logic [LANES-1:0][QUO_W-1:0]  quot_ff [NST];

   // setup: magnitude, rounded numerator, overflow test
   meta_type                     meta_in;
   logic [LANES-1:0][PREM_W-1:0] prem_in;
   logic [LANES-1:0][QUO_W-1:0]  nlow_in;
   logic signed [DIFF_W-1:0]     dv;
   logic [DIFF_W-1:0]            mag;
   logic [NUM_W-1:0]             num;

   always_comb begin
      meta_in.bad  = in_root.side.bad;
      meta_in.slot = in_root.side.slot;
      meta_in.half = ROOT_W'(((ROOT_W + 1)'(in_root.root) + 1'b1) >> 1);
      meta_in.den  = {in_root.root, 1'b0};
      for (int l = 0; l < LANES; l++) begin
         dv  = $signed(in_root.side.diff[l]);
         mag = (dv < 0) ? DIFF_W'(-dv) : DIFF_W'(dv);
         num = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(in_root.root);
         meta_in.neg[l] = (dv < 0);
         meta_in.ovf[l] = (DEN_W'(num[NUM_W-1:QUO_W]) >= meta_in.den);
         prem_in[l] = PREM_W'(num[NUM_W-1:QUO_W]);
         nlow_in[l] = num[QUO_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
      if (adv) begin
         meta_ff[0] <= meta_in;
         prem_ff[0] <= prem_in;
         nlow_ff[0] <= nlow_in;
         quot_ff[0] <= '0;
      end
   end

   for (genvar t = 1; t < NST; t++) begin : g_stage
      logic [LANES-1:0][PREM_W-1:0] p_in;
      logic [LANES-1:0][QUO_W-1:0]  q_in;
      logic [PREM_W-1:0]            p_sh;
      logic                         ge;

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            p_sh    = {prem_ff[t-1][l][PREM_W-2:0], nlow_ff[t-1][l][QUO_W-1]};
            ge      = (p_sh >= PREM_W'(meta_ff[t-1].den));
            p_in[l] = ge ? (p_sh - PREM_W'(meta_ff[t-1].den)) : p_sh;
            q_in[l] = {quot_ff[t-1][l][QUO_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[t] <= 1'b0;
         end else if (adv) begin
            v_ff[t] <= v_ff[t-1];
         end
         if (adv) begin
            meta_ff[t] <= meta_ff[t-1];
            prem_ff[t] <= p_in;
            quot_ff[t] <= q_in;
            for (int l = 0; l < LANES; l++) begin
               nlow_ff[t][l] <= nlow_ff[t-1][l] << 1;
            end
         end
      end
   end

   assign out_valid     = v_ff[NST-1];
   assign out_quot.bad  = meta_ff[NST-1].bad;
   assign out_quot.slot = meta_ff[NST-1].slot;
   assign out_quot.half = meta_ff[NST-1].half;
   assign out_quot.quot = quot_ff[NST-1];
   assign out_quot.ovf  = meta_ff[NST-1].ovf;
   assign out_quot.neg  = meta_ff[NST-1].neg;

endmodule
`default_nettype wire

/* rtl/rotation_matrix_to_quaternion_core.sv */
// Pipeline stages from an accepted req beat to rsp_tvalid: 2 front end, 16 root,
// 17 divider, 1 output register; one beat per cycle sustained while rsp is not stalled.
// The root and divider pipelines each resolve one bit per stage, which sets the depth.
// A stall on rsp freezes the whole pipeline; req_tready = !rsp_tvalid || rsp_tready.
// Synchronous active-high reset clears the valid bits only.
// Depends on r2q_pkg, r2q_prep, r2q_sqrt, r2q_div.
`default_nettype none
module rotation_matrix_to_quaternion_core (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [143:0]  req_tdata,   // r00 r01 r02 r10 r11 r12 r20 r21 r22, 16b each
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [63:0]   rsp_tdata,   // quat_w quat_x quat_y quat_z, 16b each
   output logic          rsp_tuser    // bad_input
);
   import r2q_pkg::*;

   logic     adv;
   logic     prep_v, root_v, quot_v;
   prep_type prep_d;
   root_type root_d;
   quot_type quot_d;

   logic                 rsp_tvalid_ff;
   logic [63:0]          rsp_tdata_ff;
   logic                 rsp_tuser_ff;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   r2q_prep u_prep (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(req_tvalid), .in_mat(mat_type'(req_tdata)),
      .out_valid(prep_v), .out_prep(prep_d)
   );

   r2q_sqrt u_sqrt (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(prep_v), .in_prep(prep_d),
      .out_valid(root_v), .out_root(root_d)
   );

   r2q_div u_div (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(root_v), .in_root(root_d),
      .out_valid(quot_v), .out_quot(quot_d)
   );

   logic [LANES-1:0][QUO_W-1:0] sat;
   logic [3:0][DATA_W-1:0]      q;
   logic [63:0]                 rsp_tdata_in;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (quot_d.neg[l]) begin
            sat[l] = (quot_d.ovf[l] || quot_d.quot[l] > SAT_NEG) ? SAT_NEG
                     : QUO_W'(-quot_d.quot[l]);
         end else begin
            sat[l] = (quot_d.ovf[l] || quot_d.quot[l] > SAT_POS) ? SAT_POS
                     : quot_d.quot[l];
         end
      end
      q = '0;
      case (quot_d.slot)
         SLOT_W: begin
            q[SLOT_W] = quot_d.half; q[SLOT_X] = sat[0];
            q[SLOT_Y] = sat[1];      q[SLOT_Z] = sat[2];
         end
         SLOT_X: begin
            q[SLOT_X] = quot_d.half; q[SLOT_W] = sat[0];
            q[SLOT_Y] = sat[1];      q[SLOT_Z] = sat[2];
         end
         SLOT_Y: begin
            q[SLOT_Y] = quot_d.half; q[SLOT_W] = sat[0];
            q[SLOT_Z] = sat[1];      q[SLOT_X] = sat[2];
         end
         SLOT_Z: begin
            q[SLOT_Z] = quot_d.half; q[SLOT_W] = sat[0];
            q[SLOT_X] = sat[1];      q[SLOT_Y] = sat[2];
         end
         default: q = '0;
      endcase
      rsp_tdata_in = quot_d.bad ? '0 : q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= quot_v;
      end
      if (adv) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= quot_d.bad;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule
`default_nettype wire

/* rtl/r2q_checker.sv */
// Port-level checks for rotation_matrix_to_quaternion_core, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none
module r2q_checker (
   input logic          clock,
   input logic          reset,
   input logic          req_tvalid,
   input logic          req_tready,
   input logic [143:0]  req_tdata,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [63:0]   rsp_tdata,
   input logic          rsp_tuser
);

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 64'd0)
      else $error("bad_input beat carries nonzero quaternion");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid set right after reset");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req stalled with empty output");

endmodule

bind rotation_matrix_to_quaternion_core r2q_checker u_r2q_checker (.*);
`default_nettype wire
